/* design/bspg_pkg.sv */
// Shared opcodes, widths and controller/datapath command types for the Bezier point generator.
`timescale 1ns / 1ps
`default_nettype none
package bspg_pkg;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_LINE  = 2'd0;
    localparam t_opcode OP_QUAD  = 2'd1;
    localparam t_opcode OP_CUBIC = 2'd2;
    localparam t_opcode OP_NONE  = 2'd3;

    localparam int OUT_WIDTH  = 32;
    localparam int LINE_WIDTH = 24;
    localparam int NUM_PTS    = 4;

    localparam int MM_NUM = 5;
    localparam int MM_DEN = 127;

    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    localparam logic [2:0] MAC_LAST = 3'd4;

    typedef struct packed {
        logic       load;
        logic       wt_a;
        logic       wt_b;
        logic       mac;
        logic [2:0] mac_step;
        logic       scale;
        logic       bias;
        logic       mag;
        logic       div;
        logic       emit;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

/* design/bspg_ctrl.sv */
// Controller state machine: sequences weight, accumulate, scale, bias, magnitude, divide and emit steps per point.
`timescale 1ns / 1ps
`default_nettype none
module bspg_ctrl #(
    parameter int SEGMENTS    = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire bspg_pkg::t_opcode        i_opcode,
    output bspg_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(SEGMENTS+1)-1:0] o_idx,
    input  wire bspg_pkg::t_dp_status     i_status
);

    localparam int IW  = $clog2(SEGMENTS + 1);
    localparam int CNW = $clog2(COORD_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WT_A,
        ST_WT_B,
        ST_MAC,
        ST_SCALE,
        ST_BIAS,
        ST_MAG,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [2:0]       r_step, n_step;
    logic [CNW-1:0]   r_cnt, n_cnt;
    logic             r_single, n_single;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_single = r_single;
        o_cmd          = '0;
        o_cmd.mac_step = r_step;
        o_cmd.last     = r_single || (r_idx == IW'(SEGMENTS));
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_opcode != bspg_pkg::OP_NONE)) begin
                    o_cmd.load = 1'b1;
                    n_single   = (i_opcode == bspg_pkg::OP_LINE);
                    n_idx      = IW'(1);
                    n_state    = ST_WT_A;
                end
            end
            ST_WT_A: begin
                o_cmd.wt_a = 1'b1;
                n_state    = ST_WT_B;
            end
            ST_WT_B: begin
                o_cmd.wt_b = 1'b1;
                n_step     = 3'd0;
                n_state    = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_step == bspg_pkg::MAC_LAST) begin
                    n_state = ST_SCALE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_BIAS;
            end
            ST_BIAS: begin
                o_cmd.bias = 1'b1;
                n_state    = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (r_cnt == CNW'(COORD_WIDTH - 1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + CNW'(1);
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (o_cmd.last) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_WT_A;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_step   <= '0;
            r_cnt    <= '0;
            r_single <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_single <= n_single;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_idx      = r_idx;

endmodule
`default_nettype wire

/* design/bspg_lane.sv */
// One coordinate lane: control points, position, multiply-accumulate and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module bspg_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int WW          = 19,
    parameter int DW          = 26
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire bspg_pkg::t_dp_cmd                     i_cmd,
    input  wire bspg_pkg::t_opcode                     i_op,
    input  wire logic signed [COORD_WIDTH-1:0]         i_p1,
    input  wire logic signed [COORD_WIDTH-1:0]         i_p2,
    input  wire logic signed [COORD_WIDTH-1:0]         i_p3,
    input  wire logic [bspg_pkg::NUM_PTS-1:0][WW-1:0]  i_w,
    input  wire logic [DW-1:0]                         i_den,
    input  wire logic                                  i_metric,
    output logic signed [bspg_pkg::OUT_WIDTH-1:0]      o_value
);

    localparam int CW  = COORD_WIDTH;
    localparam int PRW = CW + WW + 1;
    localparam int AW  = CW + WW + 2;
    localparam int SW  = AW + 3;
    localparam int MW  = SW + 2;
    localparam int RW  = DW + 1;
    localparam int OW  = bspg_pkg::OUT_WIDTH;
    localparam int EW  = (CW + 1 > OW) ? CW + 1 : OW;

    localparam logic signed [EW-1:0] SAT_HI = EW'(bspg_pkg::OUT_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(bspg_pkg::OUT_MIN);

    logic signed [CW-1:0]  r_pos;
    logic signed [CW-1:0]  r_pt [bspg_pkg::NUM_PTS];
    logic signed [PRW-1:0] r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [SW-1:0]  r_sc;
    logic signed [MW-1:0]  r_m;
    logic                  r_neg;
    logic [RW-1:0]         r_rem;
    logic [CW-1:0]         r_quo;

    logic signed [PRW-1:0] c_prod;
    logic [RW-1:0]         c_b;
    logic                  c_neg;
    logic [MW-1:0]         c_a;
    logic [MW-1:0]         c_a_hi;
    logic [RW:0]           c_sh;
    logic [RW:0]           c_sub;
    logic                  c_ge;
    logic signed [CW:0]    c_q;
    logic signed [EW-1:0]  c_qe;

    assign c_prod = PRW'($signed({1'b0, i_w[i_cmd.mac_step[1:0]]}))
                  * PRW'(r_pt[i_cmd.mac_step[1:0]]);
    assign c_b    = {i_den, 1'b0};
    assign c_neg  = r_m[MW-1];
    assign c_a    = c_neg ? (MW'(c_b) - MW'(1) - $unsigned(r_m)) : $unsigned(r_m);
    assign c_a_hi = c_a >> CW;
    assign c_sh   = {r_rem, r_quo[CW-1]};
    assign c_ge   = (c_sh >= (RW+1)'(c_b));
    assign c_sub  = c_sh - (RW+1)'(c_b);
    assign c_q    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign c_qe   = EW'(c_q);

    always_comb begin
        priority if (c_qe > SAT_HI) begin
            o_value = OW'(SAT_HI);
        end else if (c_qe < SAT_LO) begin
            o_value = OW'(SAT_LO);
        end else begin
            o_value = OW'(c_qe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load) begin
            unique case (i_op)
                bspg_pkg::OP_QUAD:  r_pos <= i_p2;
                bspg_pkg::OP_CUBIC: r_pos <= i_p3;
                default:            r_pos <= i_p1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= (i_op == bspg_pkg::OP_LINE) ? i_p1 : r_pos;
            r_pt[1] <= i_p1;
            r_pt[2] <= i_p2;
            r_pt[3] <= i_p3;
        end
        if (i_cmd.wt_b) begin
            r_acc <= '0;
        end
        if (i_cmd.mac) begin
            if (i_cmd.mac_step != bspg_pkg::MAC_LAST) begin
                r_prod <= c_prod;
            end
            if (i_cmd.mac_step != 3'd0) begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
        if (i_cmd.scale) begin
            r_sc <= i_metric ? SW'(r_acc) * SW'(bspg_pkg::MM_NUM) : SW'(r_acc);
        end
        if (i_cmd.bias) begin
            r_m <= (MW'(r_sc) <<< 1) + $signed(MW'(i_den));
        end
        if (i_cmd.mag) begin
            r_neg <= c_neg;
            r_rem <= RW'(c_a_hi);
            r_quo <= c_a[CW-1:0];
        end
        if (i_cmd.div) begin
            r_rem <= c_ge ? RW'(c_sub) : RW'(c_sh);
            r_quo <= {r_quo[CW-2:0], c_ge};
        end
    end

endmodule
`default_nettype wire

/* design/bspg_datapath.sv */
// Datapath: configuration, Bernstein weights, divisor select, two coordinate lanes, output register.
`timescale 1ns / 1ps
`default_nettype none
module bspg_datapath #(
    parameter int SEGMENTS    = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_data,
    input  wire bspg_pkg::t_dp_cmd                    i_cmd,
    input  wire logic [$clog2(SEGMENTS+1)-1:0]        i_idx,
    output bspg_pkg::t_dp_status                      o_status,
    input  wire bspg_pkg::t_opcode                    i_opcode,
    input  wire logic [bspg_pkg::LINE_WIDTH-1:0]      i_line_number,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p3_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [bspg_pkg::OUT_WIDTH-1:0]     o_out_x,
    output logic signed [bspg_pkg::OUT_WIDTH-1:0]     o_out_y,
    output logic [bspg_pkg::LINE_WIDTH-1:0]           o_out_line,
    output logic                                      o_last_point
);

    localparam int     IW      = $clog2(SEGMENTS + 1);
    localparam int     PW      = 3 * IW + 2;
    localparam longint SEG2    = longint'(SEGMENTS) * longint'(SEGMENTS);
    localparam longint SEG3    = SEG2 * longint'(SEGMENTS);
    localparam int     WW      = $clog2(SEG3 + 1);
    localparam longint DEN_MAX = SEG3 * longint'(bspg_pkg::MM_DEN);
    localparam int     DW      = $clog2(DEN_MAX + 1);
    localparam int     NP      = bspg_pkg::NUM_PTS;
    localparam int     OW      = bspg_pkg::OUT_WIDTH;

    localparam logic [DW-1:0] DEN_LINE    = DW'(1);
    localparam logic [DW-1:0] DEN_QUAD    = DW'(SEG2);
    localparam logic [DW-1:0] DEN_CUBIC   = DW'(SEG3);
    localparam logic [DW-1:0] DEN_LINE_M  = DW'(longint'(bspg_pkg::MM_DEN));
    localparam logic [DW-1:0] DEN_QUAD_M  = DW'(SEG2 * longint'(bspg_pkg::MM_DEN));
    localparam logic [DW-1:0] DEN_CUBIC_M = DW'(DEN_MAX);

    logic                              r_metric;
    bspg_pkg::t_opcode                 r_op;
    logic [bspg_pkg::LINE_WIDTH-1:0]   r_line;
    logic [2*IW-1:0]                   r_uu, r_ii, r_iu;
    logic [NP-1:0][WW-1:0]             r_w;
    logic [DW-1:0]                     r_den;
    logic                              r_out_valid;
    logic signed [OW-1:0]              r_out_x, r_out_y;
    logic [bspg_pkg::LINE_WIDTH-1:0]   r_out_line;
    logic                              r_out_last;

    logic [IW-1:0]        c_u;
    logic [PW-1:0]        c_uuu, c_iuu, c_iiu, c_iii;
    logic signed [OW-1:0] c_x, c_y;

    assign c_u   = IW'(SEGMENTS) - i_idx;
    assign c_uuu = PW'(r_uu) * PW'(c_u);
    assign c_iuu = PW'(r_iu) * PW'(c_u);
    assign c_iiu = PW'(r_ii) * PW'(c_u);
    assign c_iii = PW'(r_ii) * PW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= 1'b0;
        end else if (i_cfg_we) begin
            r_metric <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_line <= i_line_number;
        end
        if (i_cmd.wt_a) begin
            r_uu <= (2*IW)'(c_u) * (2*IW)'(c_u);
            r_ii <= (2*IW)'(i_idx) * (2*IW)'(i_idx);
            r_iu <= (2*IW)'(i_idx) * (2*IW)'(c_u);
        end
        if (i_cmd.wt_b) begin
            unique case (r_op)
                bspg_pkg::OP_QUAD: begin
                    r_w[0] <= WW'(r_uu);
                    r_w[1] <= WW'({r_iu, 1'b0});
                    r_w[2] <= WW'(r_ii);
                    r_w[3] <= '0;
                    r_den  <= r_metric ? DEN_QUAD_M : DEN_QUAD;
                end
                bspg_pkg::OP_CUBIC: begin
                    r_w[0] <= WW'(c_uuu);
                    r_w[1] <= WW'(c_iuu + (c_iuu << 1));
                    r_w[2] <= WW'(c_iiu + (c_iiu << 1));
                    r_w[3] <= WW'(c_iii);
                    r_den  <= r_metric ? DEN_CUBIC_M : DEN_CUBIC;
                end
                default: begin
                    r_w[0] <= WW'(1);
                    r_w[1] <= '0;
                    r_w[2] <= '0;
                    r_w[3] <= '0;
                    r_den  <= r_metric ? DEN_LINE_M : DEN_LINE;
                end
            endcase
        end
    end

    bspg_lane #(
        .COORD_WIDTH (COORD_WIDTH),
        .WW          (WW),
        .DW          (DW)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_op     (i_opcode),
        .i_p1     (i_p1_x),
        .i_p2     (i_p2_x),
        .i_p3     (i_p3_x),
        .i_w      (r_w),
        .i_den    (r_den),
        .i_metric (r_metric),
        .o_value  (c_x)
    );

    bspg_lane #(
        .COORD_WIDTH (COORD_WIDTH),
        .WW          (WW),
        .DW          (DW)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_op     (i_opcode),
        .i_p1     (i_p1_y),
        .i_p2     (i_p2_y),
        .i_p3     (i_p3_y),
        .i_w      (r_w),
        .i_den    (r_den),
        .i_metric (r_metric),
        .o_value  (c_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x    <= c_x;
            r_out_y    <= c_y;
            r_out_line <= r_line;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_x           = r_out_x;
    assign o_out_y           = r_out_y;
    assign o_out_line        = r_out_line;
    assign o_last_point      = r_out_last;

endmodule
`default_nettype wire

/* design/bezier_spline_point_generator_unit.sv */
// Top level of the Bezier point generator: controller plus datapath.
//
//   channel   direction  handshake                   payload
//   in        request    i_in_valid / o_in_ready     opcode, line number, p1..p3 X/Y
//   out       result     o_out_valid / i_out_ready   out_x, out_y, out_line, last_point
//   cfg       write      i_cfg_we                    i_cfg_data (metric_units)
//
// Each point runs the weight steps, the multiply-accumulate, scale and sign, the
// restoring divider bit by bit, and then the output load. A curve yields SEGMENTS points,
// a straight move one point; after the last point the generator is idle again and
// accepts the next request.
// Synchronous active-low reset clears position to zero and metric mode to inches.
// A stalled output holds the point generator in its emit step; a request is taken
// whenever the generator is idle, even with a result still waiting.
`timescale 1ns / 1ps
`default_nettype none
module bezier_spline_point_generator_unit #(
    parameter int SEGMENTS    = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic [bspg_pkg::LINE_WIDTH-1:0]      i_line_number,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_p3_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [bspg_pkg::OUT_WIDTH-1:0]     o_out_x,
    output logic signed [bspg_pkg::OUT_WIDTH-1:0]     o_out_y,
    output logic [bspg_pkg::LINE_WIDTH-1:0]           o_out_line,
    output logic                                      o_last_point
);

    localparam int IW = $clog2(SEGMENTS + 1);

    bspg_pkg::t_dp_cmd    w_cmd;
    bspg_pkg::t_dp_status w_status;
    logic [IW-1:0]        w_idx;

    bspg_ctrl #(
        .SEGMENTS    (SEGMENTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .i_status   (w_status)
    );

    bspg_datapath #(
        .SEGMENTS    (SEGMENTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .o_status      (w_status),
        .i_opcode      (i_opcode),
        .i_line_number (i_line_number),
        .i_p1_x        (i_p1_x),
        .i_p1_y        (i_p1_y),
        .i_p2_x        (i_p2_x),
        .i_p2_y        (i_p2_y),
        .i_p3_x        (i_p3_x),
        .i_p3_y        (i_p3_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_line    (o_out_line),
        .o_last_point  (o_last_point)
    );

endmodule
`default_nettype wire
